### src/nsvfd_pkg.sv
// Package for the NSV frame deframer: fourcc codes, header bytes,
// frame counter width, result kind codes and video codec codes.
// No dependencies.
package nsvfd_pkg;

    localparam int FRAME_COUNT_WIDTH = 32;

    localparam logic [31:0] FOURCC_NSVS = 32'h4E53_5673;
    localparam logic [31:0] FOURCC_VP61 = 32'h5650_3631;
    localparam logic [31:0] FOURCC_VP62 = 32'h5650_3632;
    localparam logic [31:0] FOURCC_NONE = 32'h4E4F_4E45;
    localparam logic [31:0] FOURCC_PCM  = 32'h5043_4D20;

    localparam logic [7:0] BEEF_LO     = 8'hEF;
    localparam logic [7:0] BEEF_HI     = 8'hBE;
    localparam logic [7:0] VP61_KEY    = 8'h36;
    localparam logic [7:0] VP62_KEY    = 8'h46;
    localparam int         AUX_HDR_LEN = 6;

    typedef enum logic [1:0] {
        KIND_VIDEO  = 2'd0,
        KIND_AUDIO  = 2'd1,
        KIND_PREFIX = 2'd2
    } stream_kind_t;

    typedef enum logic [1:0] {
        VCODEC_OTHER = 2'd0,
        VCODEC_VP61  = 2'd1,
        VCODEC_VP62  = 2'd2
    } video_codec_t;

endpackage

### src/nsv_frame_deframer.sv
// NSV frame deframer top level: sync hunt, header parsing, payload pass-through.
// Depends on nsvfd_pkg.
//
//   channel  signals                                   direction
//   in       in_valid, in_ready, stream_byte           byte stream in
//   out      out_valid, out_ready, stream_kind,        payload/prefix byte out
//            data_byte, first_of_packet, last_of_packet,
//            keyframe, frame_number, had_sync
//
// One input byte per cycle while in_ready is high; each byte updates the parser
// state in the same cycle it is taken and yields at most one result into the
// output register; results appear in the cycle after the byte transfer.
// in_ready stays high while the output register is empty or being drained,
// so a stall on out holds at most one result and blocks further input.
// Reset returns the parser to sync hunting with all counts cleared.
module nsv_frame_deframer
    import nsvfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  stream_kind,
    output logic [7:0]  data_byte,
    output logic        first_of_packet,
    output logic        last_of_packet,
    output logic        keyframe,
    output logic [31:0] frame_number,
    output logic        had_sync
);

    typedef enum logic [3:0] {
        PH_HUNT   = 4'd0,
        PH_SYNC   = 4'd1,
        PH_BEEF0  = 4'd2,
        PH_BEEF1  = 4'd3,
        PH_PHDR   = 4'd4,
        PH_AUXH   = 4'd5,
        PH_AUXD   = 4'd6,
        PH_VIDEO  = 4'd7,
        PH_PREFIX = 4'd8,
        PH_AUDIO  = 4'd9
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [31:0]                    window_reg, window_next;
    logic [19:0]                    field_count_reg, field_count_next;
    logic [19:0]                    video_rem_reg, video_rem_next;
    logic [15:0]                    audio_rem_reg, audio_rem_next;
    logic [3:0]                     aux_left_reg, aux_left_next;
    logic [15:0]                    aux_chunk_reg, aux_chunk_next;
    video_codec_t                   video_kind_reg, video_kind_next;
    logic                           video_present_reg, video_present_next;
    logic                           audio_present_reg, audio_present_next;
    logic                           pcm_audio_reg, pcm_audio_next;
    logic                           pcm_pending_reg, pcm_pending_next;
    logic                           header_seen_reg, header_seen_next;
    logic                           sync_led_reg, sync_led_next;
    logic                           key_flag_reg, key_flag_next;
    logic [FRAME_COUNT_WIDTH-1:0]   frame_count_reg, frame_count_next;

    logic                           out_valid_reg;
    logic [1:0]                     kind_reg;
    logic [7:0]                     data_reg;
    logic                           first_reg;
    logic                           last_reg;
    logic                           key_reg;
    logic [31:0]                    fnum_reg;
    logic                           had_sync_reg;

    logic                           emit;
    stream_kind_t                   emit_kind;
    logic                           emit_first;
    logic                           emit_last;
    logic                           emit_key;
    logic [31:0]                    emit_fnum;
    logic                           in_xfer;
    logic                           is_first;
    logic                           is_last;
    logic [16:0]                    aux_need;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        phase_next         = phase_reg;
        window_next        = window_reg;
        field_count_next   = field_count_reg;
        video_rem_next     = video_rem_reg;
        audio_rem_next     = audio_rem_reg;
        aux_left_next      = aux_left_reg;
        aux_chunk_next     = aux_chunk_reg;
        video_kind_next    = video_kind_reg;
        video_present_next = video_present_reg;
        audio_present_next = audio_present_reg;
        pcm_audio_next     = pcm_audio_reg;
        pcm_pending_next   = pcm_pending_reg;
        header_seen_next   = header_seen_reg;
        sync_led_next      = sync_led_reg;
        key_flag_next      = key_flag_reg;
        frame_count_next   = frame_count_reg;
        emit               = 1'b0;
        emit_kind          = KIND_VIDEO;
        emit_first         = 1'b0;
        emit_last          = 1'b0;
        emit_key           = 1'b0;
        emit_fnum          = '0;
        is_first           = 1'b0;
        is_last            = 1'b0;
        aux_need           = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                window_next = {window_reg[23:0], stream_byte};
                if (window_next == FOURCC_NSVS)
                begin
                    phase_next       = PH_SYNC;
                    field_count_next = '0;
                end
            end
            PH_SYNC:
            begin
                window_next = {window_reg[23:0], stream_byte};
                if (field_count_reg == 20'd3 && !header_seen_reg)
                begin
                    video_present_next = window_next != FOURCC_NONE;
                    video_kind_next    = (window_next == FOURCC_VP61) ? VCODEC_VP61 :
                                         (window_next == FOURCC_VP62) ? VCODEC_VP62 :
                                                                        VCODEC_OTHER;
                end
                if (field_count_reg == 20'd7 && !header_seen_reg)
                begin
                    audio_present_next = window_next != FOURCC_NONE;
                    pcm_audio_next     = window_next == FOURCC_PCM;
                    pcm_pending_next   = window_next == FOURCC_PCM;
                end
                if (field_count_reg >= 20'd14)
                begin
                    header_seen_next = 1'b1;
                    sync_led_next    = 1'b1;
                    phase_next       = PH_PHDR;
                    field_count_next = '0;
                end
                else
                begin
                    field_count_next = field_count_reg + 20'd1;
                end
            end
            PH_BEEF0:
            begin
                if (stream_byte == BEEF_LO)
                begin
                    phase_next = PH_BEEF1;
                end
                else
                begin
                    window_next = {24'd0, stream_byte};
                    phase_next  = PH_HUNT;
                end
            end
            PH_BEEF1:
            begin
                if (stream_byte == BEEF_HI)
                begin
                    sync_led_next    = 1'b0;
                    phase_next       = PH_PHDR;
                    field_count_next = '0;
                end
                else
                begin
                    window_next = {16'd0, BEEF_LO, stream_byte};
                    phase_next  = PH_HUNT;
                end
            end
            PH_PHDR:
            begin
                case (field_count_reg)
                    20'd0:
                    begin
                        aux_left_next  = stream_byte[3:0];
                        video_rem_next = {16'd0, stream_byte[7:4]};
                    end
                    20'd1:   video_rem_next = video_rem_reg | {8'd0, stream_byte, 4'd0};
                    20'd2:   video_rem_next = video_rem_reg | {stream_byte, 12'd0};
                    20'd3:   audio_rem_next = {8'd0, stream_byte};
                    default: audio_rem_next = audio_rem_reg | {stream_byte, 8'd0};
                endcase
                if (field_count_reg >= 20'd4)
                begin
                    field_count_next = '0;
                    if (aux_left_next != 4'd0)
                        phase_next = PH_AUXH;
                    else if (video_rem_next != 20'd0)
                    begin
                        phase_next    = PH_VIDEO;
                        key_flag_next = (video_kind_next == VCODEC_OTHER) ? sync_led_next
                                                                          : 1'b0;
                    end
                    else if (audio_rem_next == 16'd0)
                        phase_next = PH_BEEF0;
                    else if (audio_present_next && pcm_audio_next)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_AUDIO;
                end
                else
                begin
                    field_count_next = field_count_reg + 20'd1;
                end
            end
            PH_AUXH:
            begin
                if (field_count_reg == 20'd0)
                begin
                    aux_chunk_next = {8'd0, stream_byte};
                end
                else if (field_count_reg == 20'd1)
                begin
                    aux_chunk_next = aux_chunk_reg | {stream_byte, 8'd0};
                    aux_need       = {1'b0, aux_chunk_next} + 17'(AUX_HDR_LEN);
                    video_rem_next = (video_rem_reg > {3'd0, aux_need})
                                     ? video_rem_reg - {3'd0, aux_need} : 20'd0;
                end
                if (field_count_reg >= 20'd5)
                begin
                    aux_left_next    = aux_left_reg - 4'd1;
                    field_count_next = '0;
                    if (aux_chunk_next != 16'd0)
                        phase_next = PH_AUXD;
                    else if (aux_left_next != 4'd0)
                        phase_next = PH_AUXH;
                    else if (video_rem_next != 20'd0)
                    begin
                        phase_next    = PH_VIDEO;
                        key_flag_next = (video_kind_next == VCODEC_OTHER) ? sync_led_next
                                                                          : 1'b0;
                    end
                    else if (audio_rem_next == 16'd0)
                        phase_next = PH_BEEF0;
                    else if (audio_present_next && pcm_audio_next)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_AUDIO;
                end
                else
                begin
                    field_count_next = field_count_reg + 20'd1;
                end
            end
            PH_AUXD:
            begin
                aux_chunk_next = aux_chunk_reg - 16'd1;
                if (aux_chunk_next == 16'd0)
                begin
                    field_count_next = '0;
                    if (aux_left_next != 4'd0)
                        phase_next = PH_AUXH;
                    else if (video_rem_next != 20'd0)
                    begin
                        phase_next    = PH_VIDEO;
                        key_flag_next = (video_kind_next == VCODEC_OTHER) ? sync_led_next
                                                                          : 1'b0;
                    end
                    else if (audio_rem_next == 16'd0)
                        phase_next = PH_BEEF0;
                    else if (audio_present_next && pcm_audio_next)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_AUDIO;
                end
            end
            PH_VIDEO:
            begin
                is_first = field_count_reg == 20'd0;
                is_last  = video_rem_reg == 20'd1;
                if (field_count_reg == 20'd1)
                begin
                    if ((video_kind_reg == VCODEC_VP61 && stream_byte == VP61_KEY) ||
                        (video_kind_reg == VCODEC_VP62 && stream_byte == VP62_KEY))
                        key_flag_next = 1'b1;
                end
                field_count_next = field_count_reg + 20'd1;
                video_rem_next   = video_rem_reg - 20'd1;
                emit             = video_present_reg;
                emit_kind        = KIND_VIDEO;
                emit_first       = is_first;
                emit_last        = is_last;
                emit_key         = is_last && key_flag_next;
                emit_fnum        = 32'(frame_count_reg);
                if (is_last)
                begin
                    if (video_present_reg)
                        frame_count_next = frame_count_reg + FRAME_COUNT_WIDTH'(1);
                    field_count_next = '0;
                    if (audio_rem_reg == 16'd0)
                        phase_next = PH_BEEF0;
                    else if (audio_present_reg && pcm_audio_reg)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_AUDIO;
                end
            end
            PH_PREFIX:
            begin
                is_first         = field_count_reg == 20'd0;
                is_last          = field_count_reg == 20'd3 || audio_rem_reg == 16'd1;
                emit             = pcm_pending_reg;
                emit_kind        = KIND_PREFIX;
                emit_first       = is_first;
                emit_last        = is_last;
                field_count_next = field_count_reg + 20'd1;
                audio_rem_next   = audio_rem_reg - 16'd1;
                if (is_last)
                begin
                    pcm_pending_next = 1'b0;
                    field_count_next = '0;
                    phase_next       = (audio_rem_next != 16'd0) ? PH_AUDIO : PH_BEEF0;
                end
            end
            PH_AUDIO:
            begin
                is_first         = field_count_reg == 20'd0;
                is_last          = audio_rem_reg <= 16'd1;
                field_count_next = field_count_reg + 20'd1;
                audio_rem_next   = (audio_rem_reg != 16'd0) ? audio_rem_reg - 16'd1 : 16'd0;
                if (is_last)
                    phase_next = PH_BEEF0;
                emit             = audio_present_reg;
                emit_kind        = KIND_AUDIO;
                emit_first       = is_first;
                emit_last        = is_last;
            end
            default:
            begin
                phase_next  = PH_HUNT;
                window_next = {24'd0, stream_byte};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT;
            window_reg        <= '0;
            field_count_reg   <= '0;
            video_rem_reg     <= '0;
            audio_rem_reg     <= '0;
            aux_left_reg      <= '0;
            aux_chunk_reg     <= '0;
            video_kind_reg    <= VCODEC_OTHER;
            video_present_reg <= 1'b0;
            audio_present_reg <= 1'b0;
            pcm_audio_reg     <= 1'b0;
            pcm_pending_reg   <= 1'b0;
            header_seen_reg   <= 1'b0;
            sync_led_reg      <= 1'b0;
            key_flag_reg      <= 1'b0;
            frame_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg         <= phase_next;
                window_reg        <= window_next;
                field_count_reg   <= field_count_next;
                video_rem_reg     <= video_rem_next;
                audio_rem_reg     <= audio_rem_next;
                aux_left_reg      <= aux_left_next;
                aux_chunk_reg     <= aux_chunk_next;
                video_kind_reg    <= video_kind_next;
                video_present_reg <= video_present_next;
                audio_present_reg <= audio_present_next;
                pcm_audio_reg     <= pcm_audio_next;
                pcm_pending_reg   <= pcm_pending_next;
                header_seen_reg   <= header_seen_next;
                sync_led_reg      <= sync_led_next;
                key_flag_reg      <= key_flag_next;
                frame_count_reg   <= frame_count_next;
                out_valid_reg     <= emit;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result register only on a transfer that produces a result.
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            kind_reg     <= emit_kind;
            data_reg     <= stream_byte;
            first_reg    <= emit_first;
            last_reg     <= emit_last;
            key_reg      <= emit_key;
            fnum_reg     <= emit_fnum;
            had_sync_reg <= sync_led_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign stream_kind     = kind_reg;
    assign data_byte       = data_reg;
    assign first_of_packet = first_reg;
    assign last_of_packet  = last_reg;
    assign keyframe        = key_reg;
    assign frame_number    = fnum_reg;
    assign had_sync        = had_sync_reg;

endmodule

### tb/tb_top.sv
// Self-checking testbench for nsv_frame_deframer: fixed stimulus table, then random NSV frames.
// A byte-level parser model predicts payload/prefix results of untyped bytes; checked in order.
// Depends on nsvfd_pkg and the nsv_frame_deframer RTL.
module tb_top;
    import nsvfd_pkg::*;

    localparam int DIRECTED_LEN = 27;
    localparam int RANDOM_ITEMS = 1400;
    localparam int MAX_REPORTS = 20;
    localparam longint TIMEOUT = 5_000_000;

    typedef struct packed {
        stream_kind_t kind;
        logic [7:0]   data;
        logic         first;
        logic         last;
        logic         key;
        logic [31:0]  fnum;
        logic         had_sync;
    } payload_t;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        payload_t   want;
    } stim_row_t;

    typedef enum logic [3:0] {
        ST_HUNT, ST_SYNC, ST_BEEF0, ST_BEEF1, ST_PHDR,
        ST_AUXH, ST_AUXD, ST_VIDEO, ST_PREFIX, ST_AUDIO
    } parse_state_t;

    localparam payload_t NO_RESULT = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  stream_byte;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  stream_kind;
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic        last_of_packet;
    logic        keyframe;
    logic [31:0] frame_number;
    logic        had_sync;

    // parser model state
    logic [31:0]                  win = '0;
    parse_state_t                 pstate = ST_HUNT;
    logic [19:0]                  fcount = '0;
    logic [19:0]                  vid_left = '0;
    logic [15:0]                  aud_left = '0;
    logic [3:0]                   aux_cnt = '0;
    logic [15:0]                  chunk_left = '0;
    video_codec_t                 vcodec = VCODEC_OTHER;
    logic                         vid_on = 1'b0;
    logic                         aud_on = 1'b0;
    logic                         pcm = 1'b0;
    logic                         pcm_pending = 1'b0;
    logic                         hdr_seen = 1'b0;
    logic                         sync_led = 1'b0;
    logic                         key_now = 1'b0;
    logic [FRAME_COUNT_WIDTH-1:0] frames = '0;

    payload_t due_payload[$];
    payload_t want_r;
    int       bytes_sent = 0;
    int       results_seen = 0;
    int       keyframes_seen = 0;
    int       packets_seen = 0;
    int       mismatches = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       stall_left = 0;
    bit       drained = 1'b0;

    stim_row_t dir_rows [DIRECTED_LEN] = '{
        '{8'h4E, 1'b0, NO_RESULT}, '{8'h53, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT}, '{8'h73, 1'b0, NO_RESULT},
        '{8'h56, 1'b0, NO_RESULT}, '{8'h50, 1'b0, NO_RESULT},
        '{8'h36, 1'b0, NO_RESULT}, '{8'h31, 1'b0, NO_RESULT},
        '{8'h50, 1'b0, NO_RESULT}, '{8'h43, 1'b0, NO_RESULT},
        '{8'h4D, 1'b0, NO_RESULT}, '{8'h20, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h20, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT}, '{8'h01, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{KIND_VIDEO, 8'hFF, 1'b1, 1'b0, 1'b0, 32'd0, 1'b1}},
        '{8'h36, 1'b1, '{KIND_VIDEO, 8'h36, 1'b0, 1'b1, 1'b1, 32'd0, 1'b1}},
        '{8'h00, 1'b1, '{KIND_PREFIX, 8'h00, 1'b1, 1'b1, 1'b0, 32'd0, 1'b1}}
    };

    nsv_frame_deframer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .stream_kind    (stream_kind),
        .data_byte      (data_byte),
        .first_of_packet(first_of_packet),
        .last_of_packet (last_of_packet),
        .keyframe       (keyframe),
        .frame_number   (frame_number),
        .had_sync       (had_sync)
    );

    always #5 clk = ~clk;

    function automatic void open_audio();
        fcount = '0;
        if (aud_left == 0)
            pstate = ST_BEEF0;
        else if (aud_on && pcm)
            pstate = ST_PREFIX;
        else
            pstate = ST_AUDIO;
    endfunction

    function automatic void open_video();
        fcount = '0;
        if (vid_left != 0)
        begin
            pstate = ST_VIDEO;
            key_now = (vcodec == VCODEC_OTHER) ? sync_led : 1'b0;
        end
        else
        begin
            open_audio();
        end
    endfunction

    function automatic void next_aux_chunk();
        fcount = '0;
        if (aux_cnt != 0)
            pstate = ST_AUXH;
        else
            open_video();
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output payload_t res);
        logic        first_b;
        logic        last_b;
        logic [20:0] need;
        bit          made;
        made = 1'b0;
        res = NO_RESULT;
        case (pstate)
            ST_HUNT:
            begin
                win = {win[23:0], b};
                if (win == FOURCC_NSVS)
                begin
                    pstate = ST_SYNC;
                    fcount = '0;
                end
            end
            ST_SYNC:
            begin
                win = {win[23:0], b};
                if (fcount == 3 && !hdr_seen)
                begin
                    vid_on = (win != FOURCC_NONE);
                    vcodec = (win == FOURCC_VP61) ? VCODEC_VP61 :
                             (win == FOURCC_VP62) ? VCODEC_VP62 : VCODEC_OTHER;
                end
                if (fcount == 7 && !hdr_seen)
                begin
                    aud_on = (win != FOURCC_NONE);
                    pcm = (win == FOURCC_PCM);
                    pcm_pending = pcm;
                end
                if (fcount >= 14)
                begin
                    hdr_seen = 1'b1;
                    sync_led = 1'b1;
                    pstate = ST_PHDR;
                    fcount = '0;
                end
                else
                begin
                    fcount++;
                end
            end
            ST_BEEF0:
            begin
                if (b == BEEF_LO)
                    pstate = ST_BEEF1;
                else
                begin
                    win = {24'd0, b};
                    pstate = ST_HUNT;
                end
            end
            ST_BEEF1:
            begin
                if (b == BEEF_HI)
                begin
                    sync_led = 1'b0;
                    pstate = ST_PHDR;
                    fcount = '0;
                end
                else
                begin
                    win = {16'd0, BEEF_LO, b};
                    pstate = ST_HUNT;
                end
            end
            ST_PHDR:
            begin
                case (fcount)
                    20'd0:
                    begin
                        aux_cnt = b[3:0];
                        vid_left = {16'd0, b[7:4]};
                    end
                    20'd1: vid_left[11:4] = b;
                    20'd2: vid_left[19:12] = b;
                    20'd3: aud_left = {8'd0, b};
                    default: aud_left[15:8] = b;
                endcase
                if (fcount >= 4)
                    next_aux_chunk();
                else
                    fcount++;
            end
            ST_AUXH:
            begin
                if (fcount == 0)
                    chunk_left = {8'd0, b};
                else if (fcount == 1)
                begin
                    chunk_left[15:8] = b;
                    need = {5'd0, chunk_left} + 21'(AUX_HDR_LEN);
                    vid_left = ({1'b0, vid_left} > need) ? vid_left - need[19:0] : '0;
                end
                if (fcount >= 5)
                begin
                    aux_cnt = aux_cnt - 4'd1;
                    if (chunk_left != 0)
                    begin
                        pstate = ST_AUXD;
                        fcount = '0;
                    end
                    else
                    begin
                        next_aux_chunk();
                    end
                end
                else
                begin
                    fcount++;
                end
            end
            ST_AUXD:
            begin
                chunk_left--;
                if (chunk_left == 0)
                    next_aux_chunk();
            end
            ST_VIDEO:
            begin
                first_b = (fcount == 0);
                last_b = (vid_left == 1);
                if (fcount == 1 && ((vcodec == VCODEC_VP61 && b == VP61_KEY) ||
                                    (vcodec == VCODEC_VP62 && b == VP62_KEY)))
                    key_now = 1'b1;
                fcount++;
                vid_left--;
                if (vid_on)
                begin
                    res = '{KIND_VIDEO, b, first_b, last_b, last_b && key_now,
                            32'(frames), sync_led};
                    made = 1'b1;
                end
                if (last_b)
                begin
                    if (vid_on)
                        frames++;
                    open_audio();
                end
            end
            ST_PREFIX:
            begin
                last_b = (fcount == 3) || (aud_left == 1);
                first_b = (fcount == 0);
                if (pcm_pending)
                begin
                    res = '{KIND_PREFIX, b, first_b, last_b, 1'b0, 32'd0, sync_led};
                    made = 1'b1;
                end
                fcount++;
                aud_left--;
                if (last_b)
                begin
                    pcm_pending = 1'b0;
                    fcount = '0;
                    pstate = (aud_left != 0) ? ST_AUDIO : ST_BEEF0;
                end
            end
            ST_AUDIO:
            begin
                first_b = (fcount == 0);
                last_b = (aud_left <= 1);
                fcount++;
                if (aud_left != 0)
                    aud_left--;
                if (last_b)
                    pstate = ST_BEEF0;
                if (aud_on)
                begin
                    res = '{KIND_AUDIO, b, first_b, last_b, 1'b0, 32'd0, sync_led};
                    made = 1'b1;
                end
            end
            default:
            begin
                pstate = ST_HUNT;
                win = {24'd0, b};
            end
        endcase
        return made;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 15;
            2: return 50;
            default: return 5;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                             input payload_t want = NO_RESULT);
        int       gap;
        payload_t res;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
        if (deframe_byte(b, res) && !typed)
            due_payload.push_back(res);
        if (typed)
            due_payload.push_back(want);
    endtask

    task automatic send_word(input logic [31:0] w);
        int i;
        for (i = 0; i < 4; i++)
            send_byte(w[31-8*i -: 8]);
    endtask

    task automatic send_sync_header();
        int r;
        send_word(FOURCC_NSVS);
        r = $urandom_range(0, 3);
        send_word(r == 0 ? FOURCC_VP61 : r == 1 ? FOURCC_VP62 :
                  r == 2 ? FOURCC_NONE : 32'($urandom));
        r = $urandom_range(0, 2);
        send_word(r == 0 ? FOURCC_PCM : r == 1 ? FOURCC_NONE : 32'($urandom));
        repeat (7) send_byte(8'($urandom));
    endtask

    task automatic send_frame();
        int          lead;
        int          r;
        logic [19:0] vlen;
        logic [15:0] alen;
        logic [3:0]  aux;
        logic [7:0]  nb;
        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();
        lead = $urandom_range(0, 99);
        if (lead < 10)
        begin
            repeat ($urandom_range(1, 12))
            begin
                nb = 8'($urandom);
                send_byte(nb == BEEF_LO ? 8'h00 : nb);
            end
            send_sync_header();
        end
        else if (lead < 20)
        begin
            send_sync_header();
        end
        else if (lead < 26)
        begin
            send_byte(BEEF_LO);
            nb = 8'($urandom);
            send_byte(nb == BEEF_HI ? 8'h00 : nb);
            send_sync_header();
        end
        else
        begin
            send_byte(BEEF_LO);
            send_byte(BEEF_HI);
        end

        r = $urandom_range(0, 99);
        aux = (r < 75) ? 4'd0 : (r < 95) ? 4'($urandom_range(1, 3)) : 4'd15;
        r = $urandom_range(0, 99);
        vlen = (r < 5) ? 20'd0 : (r < 8) ? 20'($urandom_range(200, 700))
                                         : 20'($urandom_range(1, 30));
        r = $urandom_range(0, 99);
        alen = (r < 10) ? 16'd0 : (r < 25) ? 16'($urandom_range(1, 4))
                                           : 16'($urandom_range(5, 16));
        send_byte({vlen[3:0], aux});
        send_byte(vlen[11:4]);
        send_byte(vlen[19:12]);
        send_byte(alen[7:0]);
        send_byte(alen[15:8]);

        // walk the payload until the parser expects the next frame marker
        while (pstate != ST_BEEF0)
        begin
            nb = 8'($urandom);
            if (pstate == ST_AUXH && fcount == 0)
                nb = (aux == 4'd15) ? 8'd0 : 8'($urandom_range(0, 8));
            else if (pstate == ST_AUXH && fcount == 1)
                nb = 8'd0;
            else if (pstate == ST_VIDEO && fcount == 1 && $urandom_range(0, 1))
                nb = $urandom_range(0, 1) ? VP61_KEY : VP62_KEY;
            send_byte(nb);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (due_payload.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual kind %0d byte %02h",
                             $time, stream_kind, data_byte);
            end
            else
            begin
                want_r = due_payload.pop_front();
                check_field("stream_kind", 32'(want_r.kind), 32'(stream_kind));
                check_field("data_byte", 32'(want_r.data), 32'(data_byte));
                check_field("first_of_packet", 32'(want_r.first), 32'(first_of_packet));
                check_field("last_of_packet", 32'(want_r.last), 32'(last_of_packet));
                check_field("keyframe", 32'(want_r.key), 32'(keyframe));
                check_field("frame_number", want_r.fnum, frame_number);
                check_field("had_sync", 32'(want_r.had_sync), 32'(had_sync));
                if (want_r.kind == KIND_VIDEO && want_r.last)
                begin
                    packets_seen++;
                    if (want_r.key)
                        keyframes_seen++;
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < recv_idle_pct)
        begin
            stall_left = pick_gap() - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        rst_n = 1'b0;
        in_valid = 1'b0;
        stream_byte = 8'h00;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIRECTED_LEN; i++)
            send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

        while (bytes_sent < DIRECTED_LEN + RANDOM_ITEMS)
        begin
            if (!drained && bytes_sent > DIRECTED_LEN + RANDOM_ITEMS / 2)
            begin
                // hold input until the output side has caught up
                in_valid <= 1'b0;
                do @(posedge clk); while (due_payload.size() != 0);
                drained = 1'b1;
            end
            send_frame();
        end

        in_valid <= 1'b0;
        recv_idle_pct = 0;
        do @(posedge clk); while (due_payload.size() != 0);
        repeat (20) @(posedge clk);

        $display("Sent %0d stream bytes; checked %0d payload and prefix results.",
                 bytes_sent, results_seen);
        $display("Video packets seen: %0d, of which %0d keyframes.",
                 packets_seen, keyframes_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT);
        $display("FAIL");
        $finish;
    end

endmodule
